// File: design/assert_macros.svh
// Assertion macros shared by the event queue RTL.
// Needs a clk and an active-low rst_n in the scope of each use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every clock edge outside reset.
`define IEFD_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Condition that must never hold outside reset.
`define IEFD_NEVER(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

// File: design/iefd_pkg.sv
// Shared types and constants of the input event queue with frame drain.
// No dependencies; used by every module of the block.
`timescale 1ns / 1ps
package iefd_pkg;

  localparam int QUEUE_DEPTH        = 32;
  localparam int QIDX_W             = $clog2(QUEUE_DEPTH);
  localparam int MAX_KEYS_PER_FRAME = 100;
  localparam int KEYS_W             = 7;
  localparam int MAX_RESULTS        = 32;
  localparam int NRES_W             = $clog2(MAX_RESULTS);
  // a tick emits at most MAX_RESULTS-1 events, so at most that many keys
  localparam int SEEN_DEPTH         = MAX_RESULTS - 1;
  localparam int SEEN_AW            = $clog2(SEEN_DEPTH);
  localparam int CMDQ_DEPTH         = 2;
  localparam int CMDQ_AW            = $clog2(CMDQ_DEPTH);
  localparam int CMDQ_CW            = $clog2(CMDQ_DEPTH + 1);
  localparam int DATA_W             = 44;

  localparam logic [7:0] ARROW_LO    = 8'h7b;
  localparam logic [7:0] ARROW_HI    = 8'h7e;
  localparam logic [7:0] ARROW_SHIFT = 8'h40;

  localparam logic [2:0] FUNC_KEY   = 3'd0;
  localparam logic [2:0] FUNC_MOUSE = 3'd1;
  localparam logic [2:0] FUNC_MOD   = 3'd2;
  localparam logic [2:0] FUNC_DELAY = 3'd3;
  localparam logic [2:0] FUNC_TICK  = 3'd4;

  localparam logic [2:0] KIND_END   = 3'd0;
  localparam logic [2:0] KIND_KEY   = 3'd1;
  localparam logic [2:0] KIND_MOUSE = 3'd2;
  localparam logic [2:0] KIND_MOD   = 3'd3;
  localparam logic [2:0] KIND_ACK   = 3'd4;

  typedef enum logic [1:0] {
    EV_KEY   = 2'd0,
    EV_MOUSE = 2'd1,
    EV_MOD   = 2'd2,
    EV_DELAY = 2'd3
  } ev_type_t;

  typedef struct packed {
    logic [2:0]         func;
    logic               running;
    logic [7:0]         key_code;
    logic               key_up;
    logic signed [15:0] pos_x;
    logic signed [15:0] pos_y;
    logic [7:0]         button_state;
    logic signed [3:0]  button_sel;
    logic [31:0]        modifier_bits;
  } in_item_t;

  typedef struct packed {
    logic [2:0]         kind;
    logic [7:0]         out_key;
    logic               out_up;
    logic signed [15:0] out_x;
    logic signed [15:0] out_y;
    logic [7:0]         out_state;
    logic signed [3:0]  out_button;
    logic [31:0]        out_modifiers;
    logic               accepted;
    logic               last;
  } out_item_t;

  // data layout: key {up, key}; mouse {button, state, y, x}; modifiers in [31:0]
  typedef struct packed {
    ev_type_t          ev_type;
    logic [DATA_W-1:0] data;
  } q_entry_t;

  typedef struct packed {
    logic     tick;
    logic     store;
    q_entry_t entry;
  } cmd_t;

endpackage

// File: design/input_event_queue_frame_drain.sv
// Top level of the input event queue with frame drain: front end, command
// queue and back end. Depends on iefd_pkg, iefd_front, iefd_cmdq, iefd_back.
// Path: a push ack is registered in the command queue, then in the output register.
// Throughput: one push per cycle while the command queue is not full; a frame tick
// clears the key count, reads and decides each drained event in turn, then emits its end.
// Reset: synchronous, active low; clears indices, counters, remap; ring and seen keys not reset.
`timescale 1ns / 1ps
module input_event_queue_frame_drain (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic                cfg_data,
  input  logic                in_valid,
  output logic                in_ready,
  input  iefd_pkg::in_item_t  in_item,
  output logic                out_valid,
  input  logic                out_ready,
  output iefd_pkg::out_item_t out_item
);
  import iefd_pkg::*;

  logic cmd_push, cmd_full, cmd_pop, head_valid;
  cmd_t cmd_in, cmd_head;

  iefd_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_item   (in_item),
    .cmd_push  (cmd_push),
    .cmd       (cmd_in),
    .cmd_full  (cmd_full)
  );

  iefd_cmdq u_cmdq (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (cmd_push),
    .push_data  (cmd_in),
    .full       (cmd_full),
    .pop        (cmd_pop),
    .head_valid (head_valid),
    .head       (cmd_head)
  );

  iefd_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_valid (head_valid),
    .cmd       (cmd_head),
    .cmd_pop   (cmd_pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item)
  );

endmodule

// File: design/iefd_front.sv
// Front end: holds the remap register, classifies input items into commands.
// Depends on iefd_pkg.
`timescale 1ns / 1ps
module iefd_front (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic               cfg_data,
  input  logic               in_valid,
  output logic               in_ready,
  input  iefd_pkg::in_item_t in_item,
  output logic               cmd_push,
  output iefd_pkg::cmd_t     cmd,
  input  logic               cmd_full
);
  import iefd_pkg::*;

  logic       remap_r;
  logic [7:0] key;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      remap_r <= 1'b0;
    end else if (cfg_valid) begin
      remap_r <= cfg_data;
    end
  end

  assign cfg_ready = 1'b1;
  assign in_ready  = !cmd_full;
  assign cmd_push  = in_valid && !cmd_full;

  always_comb begin
    key = in_item.key_code;
    if (remap_r && (key inside {[ARROW_LO:ARROW_HI]})) begin
      key = key - ARROW_SHIFT;
    end
  end

  always_comb begin
    cmd = '0;
    case (in_item.func)
      FUNC_KEY: begin
        cmd.store         = in_item.running;
        cmd.entry.ev_type = EV_KEY;
        cmd.entry.data    = {35'd0, in_item.key_up, key};
      end
      FUNC_MOUSE: begin
        cmd.store         = in_item.running;
        cmd.entry.ev_type = EV_MOUSE;
        cmd.entry.data    = {in_item.button_sel, in_item.button_state,
                             in_item.pos_y, in_item.pos_x};
      end
      FUNC_MOD: begin
        cmd.store         = in_item.running;
        cmd.entry.ev_type = EV_MOD;
        cmd.entry.data    = {12'd0, in_item.modifier_bits};
      end
      FUNC_DELAY: begin
        cmd.store         = 1'b1;
        cmd.entry.ev_type = EV_DELAY;
      end
      FUNC_TICK: begin
        cmd.tick = 1'b1;
      end
      default: begin
        cmd.store = 1'b0;
      end
    endcase
  end

endmodule

// File: design/iefd_cmdq.sv
// Short command queue between the front end and the back end.
// Depends on iefd_pkg.
`timescale 1ns / 1ps
module iefd_cmdq (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  iefd_pkg::cmd_t push_data,
  output logic           full,
  input  logic           pop,
  output logic           head_valid,
  output iefd_pkg::cmd_t head
);
  import iefd_pkg::*;

  cmd_t               slots_r [CMDQ_DEPTH];
  logic [CMDQ_AW-1:0] wr_r, wr_nxt, rd_r, rd_nxt;
  logic [CMDQ_CW-1:0] cnt_r, cnt_nxt;

  assign full       = (cnt_r == CMDQ_CW'(CMDQ_DEPTH));
  assign head_valid = (cnt_r != '0);
  assign head       = slots_r[rd_r];

  always_comb begin
    wr_nxt  = wr_r;
    rd_nxt  = rd_r;
    cnt_nxt = cnt_r;
    if (push) begin
      wr_nxt = (wr_r == CMDQ_AW'(CMDQ_DEPTH - 1)) ? '0 : wr_r + 1'b1;
    end
    if (pop) begin
      rd_nxt = (rd_r == CMDQ_AW'(CMDQ_DEPTH - 1)) ? '0 : rd_r + 1'b1;
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots_r[wr_r] <= push_data;
    end
  end

endmodule

// File: design/iefd_back.sv
// Back end: event ring, seen-key map, frame drain sequencer, output register.
// Depends on iefd_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module iefd_back (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cmd_valid,
  input  iefd_pkg::cmd_t      cmd,
  output logic                cmd_pop,
  output logic                out_valid,
  input  logic                out_ready,
  output iefd_pkg::out_item_t out_item
);
  import iefd_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE   = 3'b001,
    ST_READ   = 3'b010,
    ST_DECIDE = 3'b100
  } state_t;

  state_t            state_r, state_nxt;
  q_entry_t          ring [QUEUE_DEPTH];
  q_entry_t          rdata_r;
  logic [QIDX_W-1:0] wr_r, wr_nxt, rd_r, rd_nxt, wr_inc, rd_inc;
  // keys emitted this tick; entries below keys_r are live
  logic [7:0]        seen_r [SEEN_DEPTH];
  logic              seen_we, seen_hit;
  logic [KEYS_W-1:0] keys_r, keys_nxt;
  logic [NRES_W-1:0] nres_r, nres_nxt;
  logic              out_valid_r;
  out_item_t         out_item_r, out_d;
  logic              ld_out, out_free, full, mem_we, acc, key_block;

  assign wr_inc   = (wr_r == QIDX_W'(QUEUE_DEPTH - 1)) ? '0 : wr_r + 1'b1;
  assign rd_inc   = (rd_r == QIDX_W'(QUEUE_DEPTH - 1)) ? '0 : rd_r + 1'b1;
  assign full     = (wr_inc == rd_r);
  assign out_free = !out_valid_r || out_ready;
  assign acc      = cmd.store && !full;

  always_comb begin
    seen_hit = 1'b0;
    for (int i = 0; i < SEEN_DEPTH; i++) begin
      if ((KEYS_W'(i) < keys_r) && (seen_r[i] == rdata_r.data[7:0])) begin
        seen_hit = 1'b1;
      end
    end
  end

  assign key_block = seen_hit || (keys_r >= KEYS_W'(MAX_KEYS_PER_FRAME));

  always_comb begin
    state_nxt = state_r;
    wr_nxt    = wr_r;
    rd_nxt    = rd_r;
    keys_nxt  = keys_r;
    nres_nxt  = nres_r;
    cmd_pop   = 1'b0;
    mem_we    = 1'b0;
    seen_we   = 1'b0;
    ld_out    = 1'b0;
    out_d     = '0;
    case (state_r)
      ST_IDLE: begin
        if (cmd_valid && out_free) begin
          cmd_pop = 1'b1;
          if (cmd.tick) begin
            keys_nxt  = '0;
            nres_nxt  = '0;
            state_nxt = ST_READ;
          end else begin
            mem_we         = acc;
            wr_nxt         = acc ? wr_inc : wr_r;
            ld_out         = 1'b1;
            out_d.kind     = KIND_ACK;
            out_d.accepted = acc;
            out_d.last     = 1'b1;
          end
        end
      end
      ST_READ: begin
        if ((rd_r == wr_r) || (nres_r == NRES_W'(MAX_RESULTS - 1))) begin
          if (out_free) begin
            ld_out     = 1'b1;
            out_d.kind = KIND_END;
            out_d.last = 1'b1;
            state_nxt  = ST_IDLE;
          end
        end else begin
          state_nxt = ST_DECIDE;
        end
      end
      ST_DECIDE: begin
        if (out_free) begin
          ld_out = 1'b1;
          if (rdata_r.ev_type == EV_DELAY) begin
            rd_nxt     = rd_inc;
            out_d.kind = KIND_END;
            out_d.last = 1'b1;
            state_nxt  = ST_IDLE;
          end else if ((rdata_r.ev_type == EV_KEY) && key_block) begin
            out_d.kind = KIND_END;
            out_d.last = 1'b1;
            state_nxt  = ST_IDLE;
          end else begin
            rd_nxt    = rd_inc;
            nres_nxt  = nres_r + 1'b1;
            state_nxt = ST_READ;
            case (rdata_r.ev_type)
              EV_KEY: begin
                seen_we       = 1'b1;
                keys_nxt      = keys_r + 1'b1;
                out_d.kind    = KIND_KEY;
                out_d.out_key = rdata_r.data[7:0];
                out_d.out_up  = rdata_r.data[8];
              end
              EV_MOUSE: begin
                out_d.kind       = KIND_MOUSE;
                out_d.out_x      = rdata_r.data[15:0];
                out_d.out_y      = rdata_r.data[31:16];
                out_d.out_state  = rdata_r.data[39:32];
                out_d.out_button = rdata_r.data[43:40];
              end
              default: begin
                out_d.kind          = KIND_MOD;
                out_d.out_modifiers = rdata_r.data[31:0];
              end
            endcase
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      wr_r        <= '0;
      rd_r        <= '0;
      keys_r      <= '0;
      nres_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      wr_r    <= wr_nxt;
      rd_r    <= rd_nxt;
      keys_r  <= keys_nxt;
      nres_r  <= nres_nxt;
      if (ld_out) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      ring[wr_r] <= cmd.entry;
    end
    rdata_r <= ring[rd_r];
    if (seen_we) begin
      seen_r[keys_r[SEEN_AW-1:0]] <= rdata_r.data[7:0];
    end
    if (ld_out) begin
      out_item_r <= out_d;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  `IEFD_NEVER(a_no_overwrite, out_valid_r && !out_ready && ld_out, "held output overwritten")
  `IEFD_NEVER(a_no_write_full, mem_we && full, "ring written while full")
  `IEFD_NEVER(a_decide_nonempty, (state_r == ST_DECIDE) && (rd_r == wr_r), "empty drain")
  `IEFD_ASSERT(a_tick_clears, cmd_pop && cmd.tick |=> keys_r == '0, "key count not cleared")
  `IEFD_ASSERT(a_key_limit, keys_r <= KEYS_W'(MAX_KEYS_PER_FRAME), "key limit exceeded")

endmodule

// File: dv/testbench.sv
// Self-checking testbench for input_event_queue_frame_drain: event pushes, frame-tick
// drains and the arrow remap option, with random idling on both channels.
// Depends on iefd_pkg and the block's RTL.
`timescale 1ns / 1ps
module testbench;
  import iefd_pkg::*;

  localparam int LIMIT_CYCLES = 1000000;

  typedef struct packed {
    ev_type_t           typ;
    logic [7:0]         key;
    logic               up;
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic [7:0]         st;
    logic signed [3:0]  btn;
    logic [31:0]        mods;
  } ring_entry_t;

  typedef struct {
    in_item_t item;
    bit       sync;
  } stim_t;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      cfg_valid = 1'b0;
  logic      cfg_ready;
  logic      cfg_data = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_ready;
  in_item_t  in_item = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_item_t out_item;

  input_event_queue_frame_drain dut (
    .clk, .rst_n, .cfg_valid, .cfg_ready, .cfg_data, .in_valid, .in_ready, .in_item,
    .out_valid, .out_ready, .out_item
  );

  always #2 clk = ~clk;

  // predictor state
  ring_entry_t ring [QUEUE_DEPTH];
  int          ring_wr = 0;
  int          ring_rd = 0;
  bit [255:0]  keys_seen = '0;
  int          keys_emitted = 0;
  bit          remap_on = 1'b0;

  out_item_t   due_results[$];
  stim_t       stim_items[$];

  int  errors = 0;
  int  cycles = 0;
  int  items_sent = 0;
  int  ticks = 0;
  int  events_out = 0;
  int  drops = 0;
  int  results_seen = 0;
  bit  quiet = 1'b0;
  bit  in_fire = 1'b0;
  int  in_gap = 0;
  int  out_gap = 0;
  out_item_t want;

  function automatic bit ring_push(ring_entry_t e);
    if ((ring_wr + 1) % QUEUE_DEPTH == ring_rd) begin
      drops++;
      return 1'b0;
    end
    ring[ring_wr] = e;
    ring_wr = (ring_wr + 1) % QUEUE_DEPTH;
    return 1'b1;
  endfunction

  function automatic void predict_results(in_item_t it);
    out_item_t   r;
    ring_entry_t e;
    int          n;
    bit          acc;
    if (it.func == FUNC_TICK) begin
      keys_seen = '0;
      keys_emitted = 0;
      n = 0;
      ticks++;
      while (ring_rd != ring_wr && n < MAX_RESULTS - 1) begin
        e = ring[ring_rd];
        if (e.typ == EV_DELAY) begin
          ring_rd = (ring_rd + 1) % QUEUE_DEPTH;
          break;
        end
        if (e.typ == EV_KEY) begin
          if (keys_seen[e.key] || keys_emitted >= MAX_KEYS_PER_FRAME) break;
          keys_seen[e.key] = 1'b1;
          keys_emitted++;
        end
        r = '0;
        case (e.typ)
          EV_KEY: begin
            r.kind = KIND_KEY;
            r.out_key = e.key;
            r.out_up = e.up;
          end
          EV_MOUSE: begin
            r.kind = KIND_MOUSE;
            r.out_x = e.x;
            r.out_y = e.y;
            r.out_state = e.st;
            r.out_button = e.btn;
          end
          default: begin
            r.kind = KIND_MOD;
            r.out_modifiers = e.mods;
          end
        endcase
        due_results.push_back(r);
        n++;
        events_out++;
        ring_rd = (ring_rd + 1) % QUEUE_DEPTH;
      end
      r = '0;
      r.kind = KIND_END;
      r.last = 1'b1;
      due_results.push_back(r);
    end else begin
      e = '0;
      acc = 1'b0;
      case (it.func)
        FUNC_KEY: begin
          e.typ = EV_KEY;
          e.key = it.key_code;
          if (remap_on && it.key_code >= ARROW_LO && it.key_code <= ARROW_HI)
            e.key = it.key_code - ARROW_SHIFT;
          e.up = it.key_up;
          if (it.running) acc = ring_push(e);
        end
        FUNC_MOUSE: begin
          e.typ = EV_MOUSE;
          e.x = it.pos_x;
          e.y = it.pos_y;
          e.st = it.button_state;
          e.btn = it.button_sel;
          if (it.running) acc = ring_push(e);
        end
        FUNC_MOD: begin
          e.typ = EV_MOD;
          e.mods = it.modifier_bits;
          if (it.running) acc = ring_push(e);
        end
        FUNC_DELAY: begin
          e.typ = EV_DELAY;
          acc = ring_push(e);
        end
        default: ;
      endcase
      r = '0;
      r.kind = KIND_ACK;
      r.accepted = acc;
      r.last = 1'b1;
      due_results.push_back(r);
    end
  endfunction

  function automatic void check_field(string name, logic [31:0] exp_v, logic [31:0] got_v);
    if (exp_v !== got_v) begin
      errors++;
      if (errors <= 40)
        $display("%0t: %s mismatch: expected %h, got %h", $time, name, exp_v, got_v);
    end
  endfunction

  // monitor: checks results, then predicts for the item taken at this edge
  always @(posedge clk) begin
    if (rst_n) begin
      cycles++;
      if (cycles > LIMIT_CYCLES) begin
        $display("%0t: timeout with %0d results outstanding", $time, due_results.size());
        $display("input_event_queue_frame_drain verification failed");
        $finish;
      end
      if (out_valid && out_ready) begin
        if (due_results.size() == 0) begin
          errors++;
          $display("%0t: unexpected result, expected none, got %h", $time, out_item);
        end else begin
          want = due_results.pop_front();
          results_seen++;
          check_field("kind", want.kind, out_item.kind);
          check_field("out_key", want.out_key, out_item.out_key);
          check_field("out_up", want.out_up, out_item.out_up);
          check_field("out_x", want.out_x, out_item.out_x);
          check_field("out_y", want.out_y, out_item.out_y);
          check_field("out_state", want.out_state, out_item.out_state);
          check_field("out_button", want.out_button, out_item.out_button);
          check_field("out_modifiers", want.out_modifiers, out_item.out_modifiers);
          check_field("accepted", want.accepted, out_item.accepted);
          check_field("last", want.last, out_item.last);
        end
      end
      if (in_valid && in_ready) begin
        predict_results(in_item);
        items_sent++;
      end
    end
    in_fire <= rst_n && in_valid && in_ready;
  end

  // driver: input and result-side ready, both changed on the falling edge
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      out_ready <= 1'b0;
    end else begin
      if (!in_valid || in_fire) begin
        if (in_gap != 0) begin
          in_gap--;
          in_valid <= 1'b0;
        end else if (!quiet && $urandom_range(0, 7) == 0) begin
          in_gap = $urandom_range(0, 5);
          in_valid <= 1'b0;
        end else if (stim_items.size() != 0 &&
                     !(stim_items[0].sync && due_results.size() != 0)) begin
          in_item <= stim_items[0].item;
          void'(stim_items.pop_front());
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
      if (out_gap != 0) begin
        out_gap--;
        out_ready <= 1'b0;
      end else if (!quiet && $urandom_range(0, 7) == 0) begin
        out_gap = $urandom_range(0, 5);
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  function automatic in_item_t rand_fields();
    logic [95:0] raw;
    raw = {$urandom, $urandom, $urandom};
    return raw[$bits(in_item_t)-1:0];
  endfunction

  function automatic in_item_t plain(logic [2:0] func, logic running);
    in_item_t it;
    it = rand_fields();
    it.func = func;
    it.running = running;
    return it;
  endfunction

  function automatic in_item_t key_item(logic [7:0] code, logic up, logic running);
    in_item_t it;
    it = plain(FUNC_KEY, running);
    it.key_code = code;
    it.key_up = up;
    return it;
  endfunction

  function automatic in_item_t mouse_item(logic signed [15:0] x, logic signed [15:0] y,
                                          logic [7:0] st, logic signed [3:0] btn);
    in_item_t it;
    it = plain(FUNC_MOUSE, 1'b1);
    it.pos_x = x;
    it.pos_y = y;
    it.button_state = st;
    it.button_sel = btn;
    return it;
  endfunction

  function automatic in_item_t mod_item(logic [31:0] bits);
    in_item_t it;
    it = plain(FUNC_MOD, 1'b1);
    it.modifier_bits = bits;
    return it;
  endfunction

  function automatic void queue_item(in_item_t it, bit sync = 1'b0);
    stim_t s;
    s.item = it;
    s.sync = sync;
    stim_items.push_back(s);
  endfunction

  function automatic logic [7:0] pick_key();
    int r;
    r = $urandom_range(0, 99);
    if (r < 40) return 8'h20 + 8'($urandom_range(0, 5));
    if (r < 65) return ARROW_LO + 8'($urandom_range(0, 3));
    if (r < 75) return ARROW_LO - ARROW_SHIFT + 8'($urandom_range(0, 3));
    return 8'($urandom_range(0, 255));
  endfunction

  // one frame: a run of pushes (sometimes enough to fill the ring), then a tick
  function automatic int gen_frame(bit sync, bit fill_only);
    in_item_t it;
    int       n;
    int       r;
    bit       fill;
    fill = fill_only || ($urandom_range(0, 7) == 0);
    n = fill ? $urandom_range(31, 36) : $urandom_range(0, 12);
    for (int i = 0; i < n; i++) begin
      it = rand_fields();
      r = fill ? $urandom_range(8, 84) : $urandom_range(0, 99);
      if (fill_only) r = $urandom_range(50, 84);
      if (r >= 8) begin
        it.running = ($urandom_range(0, 15) != 0);
        if (r < 50) begin
          it.func = FUNC_KEY;
          it.key_code = fill ? 8'($urandom_range(0, 255)) : pick_key();
        end else if (r < 68) begin
          it.func = FUNC_MOUSE;
        end else if (r < 85) begin
          it.func = FUNC_MOD;
        end else if (r < 94) begin
          it.func = FUNC_DELAY;
        end else begin
          it.func = FUNC_TICK;
        end
      end
      queue_item(it, sync && i == 0);
    end
    queue_item(plain(FUNC_TICK, 1'($urandom_range(0, 1))), sync && n == 0);
    return n + 1;
  endfunction

  task automatic write_remap(bit v);
    @(negedge clk);
    cfg_data <= v;
    cfg_valid <= 1'b1;
    forever begin
      @(posedge clk);
      if (cfg_ready) break;
    end
    remap_on = v;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic settle();
    while (stim_items.size() != 0 || in_valid || due_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic random_phase(int target);
    int queued;
    int frames;
    queued = gen_frame(1'b0, 1'b1);
    frames = 1;
    while (queued < target) begin
      queued += gen_frame(frames == 6 || $urandom_range(0, 11) == 0, 1'b0);
      frames++;
    end
    settle();
  endtask

  initial begin
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    repeat (2) @(posedge clk);

    write_remap(1'b1);
    queue_item(key_item(ARROW_LO, 1'b0, 1'b1));
    queue_item(key_item(ARROW_HI, 1'b1, 1'b1));
    queue_item(key_item(ARROW_LO - 8'd1, 1'b0, 1'b1));
    queue_item(key_item(ARROW_HI + 8'd1, 1'b1, 1'b1));
    queue_item(key_item(8'h00, 1'b0, 1'b1));
    queue_item(key_item(8'hff, 1'b1, 1'b1));
    queue_item(mouse_item(-16'sd32768, 16'sd32767, 8'hff, -4'sd1));
    queue_item(mouse_item(16'sd32767, -16'sd32768, 8'h00, 4'sd7));
    queue_item(mod_item(32'hffff_ffff));
    queue_item(mod_item(32'h0));
    // same code as the remapped arrow: the drain stops in front of it
    queue_item(key_item(ARROW_LO - ARROW_SHIFT, 1'b1, 1'b1));
    queue_item(plain(FUNC_TICK, 1'b1));
    queue_item(plain(FUNC_TICK, 1'b0));
    queue_item(key_item(8'h55, 1'b0, 1'b0));
    queue_item(plain(FUNC_MOUSE, 1'b0));
    queue_item(plain(FUNC_MOD, 1'b0));
    queue_item(plain(FUNC_DELAY, 1'b0));
    queue_item(key_item(8'h10, 1'b0, 1'b1));
    queue_item(plain(FUNC_TICK, 1'b1));
    queue_item(plain(FUNC_TICK, 1'b1));
    for (int f = FUNC_TICK + 1; f < 8; f++) queue_item(plain(3'(f), 1'b1));
    queue_item(plain(FUNC_TICK, 1'b1));
    settle();
    random_phase(190);

    write_remap(1'b0);
    random_phase(190);

    write_remap(1'b1);
    quiet = 1'b1;
    random_phase(120);

    repeat (20) @(posedge clk);
    if (due_results.size() != 0) begin
      errors++;
      $display("%0t: %0d expected results never arrived", $time, due_results.size());
    end
    $display("Ran %0d items (%0d frame ticks, %0d pushes dropped), both remap settings;",
             items_sent, ticks, drops);
    $display("checked %0d results including %0d drained events, %0d errors.",
             results_seen, events_out, errors);
    if (errors == 0) begin
      $display("input_event_queue_frame_drain verification clean");
    end else begin
      $display("input_event_queue_frame_drain verification failed");
    end
    $finish;
  end

endmodule

// File: input_event_queue_frame_drain.f
+incdir+design
design/iefd_pkg.sv
design/iefd_front.sv
design/iefd_cmdq.sv
design/iefd_back.sv
design/input_event_queue_frame_drain.sv
dv/testbench.sv
